[rtl/core/drf_pkg.sv]
package drf_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [16:0] BOX_THRESHOLD_RST   = 17'd32768;
   localparam logic [16:0] CLASS_THRESHOLD_RST = 17'd16384;
   localparam logic [7:0]  NUM_CLASSES_RST     = 8'd80;
   localparam logic [5:0]  MASK_CHANNELS_RST   = 6'd32;
   localparam logic [20:0] INV_SCALE_RST       = 21'd65536;
   localparam logic [28:0] PAD_RST             = 29'd0;

   localparam logic [11:0] PIXEL_MAX = 12'd4095;
   localparam logic [16:0] CONF_MAX  = 17'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOX_THRESHOLD   = 3'd0,
      CSR_CLASS_THRESHOLD = 3'd1,
      CSR_NUM_CLASSES     = 3'd2,
      CSR_MASK_CHANNELS   = 3'd3,
      CSR_INV_SCALE_X     = 3'd4,
      CSR_INV_SCALE_Y     = 3'd5,
      CSR_PAD_X           = 3'd6,
      CSR_PAD_Y           = 3'd7
   } drf_csr_type;

   // row layout and pass rules, used by the front
   typedef struct packed {
      logic [16:0] box_threshold;
      logic [16:0] class_threshold;
      logic [7:0]  num_classes;
      logic [5:0]  mask_channels;
   } drf_rule_type;

   // letterbox undo, used by the back
   typedef struct packed {
      logic [20:0] inv_scale_x;
      logic [20:0] inv_scale_y;
      logic [28:0] pad_x;
      logic [28:0] pad_y;
   } drf_geom_type;

   // one passing row, handed from front to back
   typedef struct packed {
      logic [7:0]        class_id;
      logic [31:0]       best_score;
      logic [31:0]       objectness;
      logic [3:0][31:0]  box;
      logic [15:0]       row_index;
   } drf_entry_type;

endpackage

[rtl/core/detection_row_filter.sv]
// Takes one value word per cycle; the front never stalls while the four-entry
// candidate queue has room, and every row is at least five words long.
// A candidate goes from the queue through the multiplier stage and the output
// register before it is shown on rsp_valid; rsp_stall can hold it in each.
// Reset clears the row position, row counter, best class, queue and output valid;
// the configuration registers return to their defaults. No clearing pass.
module detection_row_filter #(
   parameter int MAX_ROWS    = 65536,
   parameter int MAX_CLASSES = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [31:0]              req_value,
   input  logic                            req_frame_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_class_id,
   output logic [16:0]                     rsp_confidence,
   output logic [11:0]                     rsp_box_left,
   output logic [11:0]                     rsp_box_top,
   output logic [11:0]                     rsp_box_width,
   output logic [11:0]                     rsp_box_height,
   output logic [15:0]                     rsp_row_index,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [drf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [drf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   drf_pkg::drf_rule_type  rule_ff, rule_in;
   drf_pkg::drf_geom_type  geom_ff, geom_in;
   drf_pkg::drf_entry_type push_entry, q_head;
   logic                   in_accept, push, pop, q_full, q_nonempty;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign in_accept = req_valid && !req_stall;

   always_comb begin
      rule_in = rule_ff;
      geom_in = geom_ff;
      if (csr_valid && csr_ready) begin
         case (drf_pkg::drf_csr_type'(csr_index))
            drf_pkg::CSR_BOX_THRESHOLD:   rule_in.box_threshold   = csr_wdata[16:0];
            drf_pkg::CSR_CLASS_THRESHOLD: rule_in.class_threshold = csr_wdata[16:0];
            drf_pkg::CSR_NUM_CLASSES:     rule_in.num_classes     = csr_wdata[7:0];
            drf_pkg::CSR_MASK_CHANNELS:   rule_in.mask_channels   = csr_wdata[5:0];
            drf_pkg::CSR_INV_SCALE_X:     geom_in.inv_scale_x     = csr_wdata[20:0];
            drf_pkg::CSR_INV_SCALE_Y:     geom_in.inv_scale_y     = csr_wdata[20:0];
            drf_pkg::CSR_PAD_X:           geom_in.pad_x           = csr_wdata[28:0];
            drf_pkg::CSR_PAD_Y:           geom_in.pad_y           = csr_wdata[28:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff.box_threshold   <= drf_pkg::BOX_THRESHOLD_RST;
         rule_ff.class_threshold <= drf_pkg::CLASS_THRESHOLD_RST;
         rule_ff.num_classes     <= drf_pkg::NUM_CLASSES_RST;
         rule_ff.mask_channels   <= drf_pkg::MASK_CHANNELS_RST;
         geom_ff.inv_scale_x     <= drf_pkg::INV_SCALE_RST;
         geom_ff.inv_scale_y     <= drf_pkg::INV_SCALE_RST;
         geom_ff.pad_x           <= drf_pkg::PAD_RST;
         geom_ff.pad_y           <= drf_pkg::PAD_RST;
      end else begin
         rule_ff <= rule_in;
         geom_ff <= geom_in;
      end
   end

   drf_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .in_value     (req_value),
      .in_frame_end (req_frame_end),
      .rule         (rule_ff),
      .push         (push),
      .push_entry   (push_entry)
   );

   drf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .nonempty   (q_nonempty),
      .head       (q_head)
   );

   drf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .geom           (geom_ff),
      .q_nonempty     (q_nonempty),
      .q_head         (q_head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_class_id   (rsp_class_id),
      .rsp_confidence (rsp_confidence),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height),
      .rsp_row_index  (rsp_row_index)
   );

endmodule

[rtl/core/drf_front.sv]
module drf_front #(
   parameter int MAX_ROWS    = 65536,
   parameter int MAX_CLASSES = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  logic signed [31:0]     in_value,
   input  logic                   in_frame_end,
   input  drf_pkg::drf_rule_type  rule,
   output logic                   push,
   output drf_pkg::drf_entry_type push_entry
);

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam logic [7:0] CLASS_CAP = (MAX_CLASSES > 255) ? 8'd255 : 8'(MAX_CLASSES);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

   logic [8:0]         pos_ff, pos_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic signed [31:0] box_ff [4];
   logic signed [31:0] obj_ff, obj_in;
   logic signed [31:0] best_ff, best_in;
   logic [7:0]         class_ff, class_in;

   logic [7:0]         nc;
   logic [8:0]         last_pos;
   logic               is_box, is_obj, is_cls, take, row_end, pass;
   logic [7:0]         cls;
   logic [ROW_W+15:0]  row_wide;

   always_comb begin
      nc       = (rule.num_classes > CLASS_CAP) ? CLASS_CAP : rule.num_classes;
      last_pos = 9'd4 + 9'(nc) + 9'(rule.mask_channels);
      is_box   = pos_ff < 9'd4;
      is_obj   = pos_ff == 9'd4;
      is_cls   = (pos_ff >= 9'd5) && (pos_ff < (9'd5 + 9'(nc)));
      cls      = 8'(pos_ff - 9'd5);
      // first maximum wins: replace only on a strictly larger score
      take     = is_cls && ((cls == 8'd0) || (in_value > best_ff));
      obj_in   = is_obj ? in_value : obj_ff;
      best_in  = take ? in_value : best_ff;
      class_in = take ? cls : class_ff;
      row_end  = pos_ff >= last_pos;
      pass     = (nc != 8'd0)
               && ($signed(33'(obj_in)) >= $signed({16'b0, rule.box_threshold}))
               && ($signed(33'(best_in)) >= $signed({16'b0, rule.class_threshold}));
      push     = in_accept && row_end && pass;

      pos_in = pos_ff;
      row_in = row_ff;
      if (in_accept) begin
         pos_in = (row_end || in_frame_end) ? 9'd0 : pos_ff + 9'd1;
         if (in_frame_end) begin
            row_in = '0;
         end else if (row_end) begin
            row_in = (row_ff == ROW_LAST) ? '0 : row_ff + ROW_W'(1);
         end
      end

      row_wide              = {16'b0, row_ff};
      push_entry.class_id   = class_in;
      push_entry.best_score = best_in;
      push_entry.objectness = obj_in;
      push_entry.row_index  = row_wide[15:0];
      for (int i = 0; i < 4; i++) begin
         push_entry.box[i] = box_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         row_ff   <= '0;
         class_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         row_ff   <= row_in;
         if (in_accept) begin
            class_ff <= class_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         obj_ff  <= obj_in;
         best_ff <= best_in;
         if (is_box) begin
            box_ff[pos_ff[1:0]] <= in_value;
         end
      end
   end

endmodule

[rtl/core/drf_queue.sv]
module drf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  drf_pkg::drf_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   nonempty,
   output drf_pkg::drf_entry_type head
);

   drf_pkg::drf_entry_type          slot_ff [drf_pkg::QUEUE_DEPTH];
   logic [drf_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [drf_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [drf_pkg::QCNT_W-1:0]      count_ff, count_in;

   always_comb begin
      full     = count_ff == drf_pkg::QCNT_W'(drf_pkg::QUEUE_DEPTH);
      nonempty = count_ff != '0;
      head     = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + drf_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + drf_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + drf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - drf_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/drf_back.sv]
module drf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  drf_pkg::drf_geom_type  geom,
   input  logic                   q_nonempty,
   input  drf_pkg::drf_entry_type q_head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_class_id,
   output logic [16:0]            rsp_confidence,
   output logic [11:0]            rsp_box_left,
   output logic [11:0]            rsp_box_top,
   output logic [11:0]            rsp_box_width,
   output logic [11:0]            rsp_box_height,
   output logic [15:0]            rsp_row_index
);

   // stage 1: products
   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_class_ff;
   logic [15:0]        s1_row_ff;
   logic signed [63:0] s1_conf_ff, s1_conf_in;
   logic signed [54:0] s1_xs_ff, s1_xs_in, s1_ys_ff, s1_ys_in;
   logic signed [53:0] s1_ws_ff, s1_ws_in, s1_hs_ff, s1_hs_in;

   // stage 2: output word
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_class_ff;
   logic [15:0]        out_row_ff;
   logic [16:0]        out_conf_ff, out_conf_in;
   logic [11:0]        out_left_ff, out_left_in, out_top_ff, out_top_in;
   logic [11:0]        out_width_ff, out_width_in, out_height_ff, out_height_in;

   logic               out_free, s1_load;
   logic signed [32:0] dx, dy;
   logic signed [63:0] conf_round;
   logic signed [57:0] lt, tp;
   logic signed [55:0] wr, hr;

   function automatic logic [11:0] clamp_pixel(input logic neg, input logic [23:0] whole);
      logic [11:0] pix;
      if (neg) begin
         pix = '0;
      end else if (whole > 24'(drf_pkg::PIXEL_MAX)) begin
         pix = drf_pkg::PIXEL_MAX;
      end else begin
         pix = whole[11:0];
      end
      return pix;
   endfunction

   always_comb begin
      out_free    = !out_valid_ff || !rsp_stall;
      s1_load     = !s1_valid_ff || out_free;
      pop         = q_nonempty && s1_load;
      s1_valid_in = s1_load ? q_nonempty : s1_valid_ff;
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

      dx = 33'($signed(q_head.box[0])) - $signed({4'b0, geom.pad_x});
      dy = 33'($signed(q_head.box[1])) - $signed({4'b0, geom.pad_y});
      s1_conf_in = $signed(q_head.best_score) * $signed(q_head.objectness);
      s1_xs_in   = dx * $signed({1'b0, geom.inv_scale_x});
      s1_ys_in   = dy * $signed({1'b0, geom.inv_scale_y});
      s1_ws_in   = $signed(q_head.box[2]) * $signed({1'b0, geom.inv_scale_x});
      s1_hs_in   = $signed(q_head.box[3]) * $signed({1'b0, geom.inv_scale_y});

      // both factors pass non-negative thresholds, so the product is never negative
      conf_round  = s1_conf_ff + 64'sd32768;
      out_conf_in = (conf_round[63:16] > 48'(drf_pkg::CONF_MAX)) ?
                    drf_pkg::CONF_MAX : conf_round[32:16];

      // twice (centre - size/2 + 1/2), floor of half of it
      lt = (58'(s1_xs_ff) <<< 1) - 58'(s1_ws_ff) + (58'sd1 <<< 32);
      tp = (58'(s1_ys_ff) <<< 1) - 58'(s1_hs_ff) + (58'sd1 <<< 32);
      wr = 56'(s1_ws_ff) + (56'sd1 <<< 31);
      hr = 56'(s1_hs_ff) + (56'sd1 <<< 31);
      out_left_in   = clamp_pixel(lt[57], 24'(lt[56:33]));
      out_top_in    = clamp_pixel(tp[57], 24'(tp[56:33]));
      out_width_in  = clamp_pixel(wr[55], 24'(wr[54:32]));
      out_height_in = clamp_pixel(hr[55], 24'(hr[54:32]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_class_ff <= q_head.class_id;
         s1_row_ff   <= q_head.row_index;
         s1_conf_ff  <= s1_conf_in;
         s1_xs_ff    <= s1_xs_in;
         s1_ys_ff    <= s1_ys_in;
         s1_ws_ff    <= s1_ws_in;
         s1_hs_ff    <= s1_hs_in;
      end
      if (out_free) begin
         out_class_ff  <= s1_class_ff;
         out_row_ff    <= s1_row_ff;
         out_conf_ff   <= out_conf_in;
         out_left_ff   <= out_left_in;
         out_top_ff    <= out_top_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_class_id   = out_class_ff;
   assign rsp_confidence = out_conf_ff;
   assign rsp_box_left   = out_left_ff;
   assign rsp_box_top    = out_top_ff;
   assign rsp_box_width  = out_width_ff;
   assign rsp_box_height = out_height_ff;
   assign rsp_row_index  = out_row_ff;

endmodule
